>>> design/lruac_pkg.sv
package lruac_pkg;

  // fixed field widths of the ports
  localparam int unsigned SET_W  = 10;
  localparam int unsigned WAY_W  = 3;
  localparam int unsigned AGES_W = 24;

  // widest set index the memories can be built for
  localparam int unsigned SET_EXT_W = 17;

  // age counter widths per cache
  localparam int unsigned DATA_AGE_BITS = 3;
  localparam int unsigned INST_AGE_BITS = 2;

  // default geometry
  localparam int unsigned DATA_WAYS_DEF = 8;
  localparam int unsigned INST_WAYS_DEF = 4;
  localparam int unsigned NUM_SETS_DEF  = 1024;

  typedef enum logic {
    CACHE_DATA = 1'b0,
    CACHE_INST = 1'b1
  } cache_sel_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD
  } lruac_state_t;

  // request into the age update logic
  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             fill;
  } upd_req_t;

endpackage

>>> design/lru_age_counter_update_unit.sv
// channel | ports                                          | direction
// input   | in_valid in_stall in_mode in_set_index         | in
//         | in_way_index in_fill_new                       |
// result  | out_valid out_stall out_cache_echo out_set_echo | out
//         | out_ages_after                                 |
//
// for each word the accept cycle issues the age memory read; the update state
// then updates the set and writes it back before the next read
// after reset a clearing pass zeroes both age memories, one set a cycle,
// with in_stall held high
// a word is taken while a result waits; a stalled result holds the update
// stage until out_stall drops
module lru_age_counter_update_unit
  import lruac_pkg::*;
#(
  parameter int unsigned DATA_WAYS = DATA_WAYS_DEF,
  parameter int unsigned INST_WAYS = INST_WAYS_DEF,
  parameter int unsigned NUM_SETS  = NUM_SETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [SET_W-1:0]  in_set_index,
  input  logic [WAY_W-1:0]  in_way_index,
  input  logic              in_fill_new,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_cache_echo,
  output logic [SET_W-1:0]  out_set_echo,
  output logic [AGES_W-1:0] out_ages_after
);

  localparam int unsigned SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned DATA_W = DATA_WAYS * DATA_AGE_BITS;
  localparam int unsigned INST_W = INST_WAYS * INST_AGE_BITS;

  // age memories, one row per set
  logic [DATA_W-1:0] data_mem [NUM_SETS];
  logic [INST_W-1:0] inst_mem [NUM_SETS];

  lruac_state_t state_r, state_nxt;

  logic [SET_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // captured word
  cache_sel_t       mode_r;
  logic [SET_W-1:0] set_r;
  logic [WAY_W-1:0] way_r;
  logic             fill_r;
  logic             set_ok_r;

  logic [DATA_W-1:0] data_rd_r;
  logic [INST_W-1:0] inst_rd_r;

  logic              out_valid_r;
  logic              cache_echo_r;
  logic [SET_W-1:0]  set_echo_r;
  logic [AGES_W-1:0] ages_r;

  logic                 accept;
  logic                 upd_fire;
  logic                 clearing;
  logic [SET_EXT_W-1:0] in_set_ext;
  logic [SET_EXT_W-1:0] cur_set_ext;
  logic [SET_AW-1:0]    rd_addr;
  logic [SET_AW-1:0]    wr_addr;
  logic                 data_we;
  logic                 inst_we;
  logic [DATA_W-1:0]    data_wd;
  logic [INST_W-1:0]    inst_wd;
  logic                 data_way_ok;
  logic                 inst_way_ok;
  upd_req_t             data_req;
  upd_req_t             inst_req;
  logic [DATA_W-1:0]    data_upd;
  logic [INST_W-1:0]    inst_upd;
  logic [AGES_W-1:0]    ages_res;

  // ---------------------------------------------------------------- control

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_stall    = 1'b1;
    clearing    = 1'b0;
    upd_fire    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_AW'(NUM_SETS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || !out_stall) begin
          upd_fire  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // ------------------------------------------------------------ capture word

  assign in_set_ext = SET_EXT_W'(in_set_index);
  assign rd_addr    = in_set_ext[SET_AW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= cache_sel_t'(in_mode);
      set_r    <= in_set_index;
      way_r    <= in_way_index;
      fill_r   <= in_fill_new;
      set_ok_r <= in_set_ext < SET_EXT_W'(NUM_SETS);
    end
  end

  // ------------------------------------------------------------ age update

  // instruction cache only looks at the low two way bits
  assign data_req.way  = way_r;
  assign data_req.fill = fill_r;
  assign inst_req.way  = {1'b0, way_r[1:0]};
  assign inst_req.fill = fill_r;

  assign data_way_ok = 4'(way_r) < 4'(DATA_WAYS);
  assign inst_way_ok = 3'(way_r[1:0]) < 3'(INST_WAYS);

  lruac_age_upd #(
    .WAYS (DATA_WAYS),
    .BITS (DATA_AGE_BITS)
  ) u_data_upd (
    .ages_i (data_rd_r),
    .req_i  (data_req),
    .ages_o (data_upd)
  );

  lruac_age_upd #(
    .WAYS (INST_WAYS),
    .BITS (INST_AGE_BITS)
  ) u_inst_upd (
    .ages_i (inst_rd_r),
    .req_i  (inst_req),
    .ages_o (inst_upd)
  );

  // result ages: zero for an unknown set, unchanged ages for an unknown way
  always_comb begin
    ages_res = '0;
    if (set_ok_r) begin
      case (mode_r)
        CACHE_DATA: ages_res = AGES_W'(data_way_ok ? data_upd : data_rd_r);
        CACHE_INST: ages_res = AGES_W'(inst_way_ok ? inst_upd : inst_rd_r);
        default:    ages_res = '0;
      endcase
    end
  end

  // ------------------------------------------------------------ memory ports

  assign cur_set_ext = SET_EXT_W'(set_r);
  assign wr_addr     = clearing ? clr_cnt_r : cur_set_ext[SET_AW-1:0];

  assign data_we = clearing ||
                   (upd_fire && set_ok_r && (mode_r == CACHE_DATA) && data_way_ok);
  assign inst_we = clearing ||
                   (upd_fire && set_ok_r && (mode_r == CACHE_INST) && inst_way_ok);
  assign data_wd = clearing ? '0 : data_upd;
  assign inst_wd = clearing ? '0 : inst_upd;

  // the write of one word lands before the next word's read is issued
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    if (accept) begin
      data_rd_r <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (inst_we) begin
      inst_mem[wr_addr] <= inst_wd;
    end
    if (accept) begin
      inst_rd_r <= inst_mem[rd_addr];
    end
  end

  // ------------------------------------------------------------ result word

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      cache_echo_r <= mode_r;
      set_echo_r   <= set_r;
      ages_r       <= ages_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cache_echo = cache_echo_r;
  assign out_set_echo   = set_echo_r;
  assign out_ages_after = ages_r;

endmodule

>>> design/lruac_age_upd.sv
module lruac_age_upd
  import lruac_pkg::*;
#(
  parameter int unsigned WAYS = DATA_WAYS_DEF,
  parameter int unsigned BITS = DATA_AGE_BITS
) (
  input  logic [WAYS*BITS-1:0] ages_i,
  input  upd_req_t             req_i,
  output logic [WAYS*BITS-1:0] ages_o
);

  localparam logic [BITS-1:0] MAX_AGE = {BITS{1'b1}};

  logic [BITS-1:0] old_age;

  // old age of the touched way, taken before any decrement
  always_comb begin
    old_age = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (req_i.way == WAY_W'(i)) begin
        old_age = ages_i[i*BITS +: BITS];
      end
    end
  end

  always_comb begin
    logic [BITS-1:0] a;
    logic            dec;
    ages_o = ages_i;
    for (int i = 0; i < WAYS; i++) begin
      a = ages_i[i*BITS +: BITS];
      if (req_i.fill) begin
        dec = (WAY_W'(i) < req_i.way) && (a != '0);
      end else begin
        dec = (a >= old_age) && (a != '0);
      end
      if (req_i.way == WAY_W'(i)) begin
        ages_o[i*BITS +: BITS] = MAX_AGE;
      end else if (dec) begin
        ages_o[i*BITS +: BITS] = a - 1'b1;
      end
    end
  end

endmodule
